/* rtl/battery_presence_level_monitor_assert.svh */
// assertion macros for the battery presence and level monitor
// used by the top level only; no other dependencies
`ifndef BATTERY_PRESENCE_LEVEL_MONITOR_ASSERT_SVH
`define BATTERY_PRESENCE_LEVEL_MONITOR_ASSERT_SVH

`ifndef SYNTHESIS
`define BPLM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bplm: same-cycle check failed");
`define BPLM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bplm: next-cycle check failed");
`else
`define BPLM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BPLM_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/bplm_pkg.sv */
// shared types, codes and reset constants for the battery presence and level monitor
// no dependencies
package bplm_pkg;

  localparam int AdcBitsDef  = 12;
  localparam int TickBitsDef = 32;
  localparam int CntW        = 8;
  localparam int CfgIdxW     = 3;
  localparam int OutDataW    = 16;

  // reset values of the configuration registers
  localparam int VbusThrRst     = 500;
  localparam int PulseThrRst    = 1500;
  localparam int FullThrRst     = 4095;
  localparam int CritThrRst     = 3900;
  localparam int HighsNeededRst = 5;
  localparam int LevelRepRst    = 10;
  localparam int BounceWinRst   = 1000;
  localparam int StableWinRst   = 2000;

  localparam logic [CntW-1:0] BouncesForDisc = 8'd4;
  localparam logic [CntW-1:0] CntMax         = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_VBUS_THR   = 3'd0,
    REG_PULSE_THR  = 3'd1,
    REG_FULL_THR   = 3'd2,
    REG_CRIT_THR   = 3'd3,
    REG_HIGHS      = 3'd4,
    REG_LEVEL_REP  = 3'd5,
    REG_BOUNCE_WIN = 3'd6,
    REG_STABLE_WIN = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_ADC    = 2'd0,
    CMD_CHARGE = 2'd1,
    CMD_PGOOD  = 2'd2,
    CMD_INIT   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PRES_UNKNOWN = 2'd0,
    PRES_CONN    = 2'd1,
    PRES_DISC    = 2'd2
  } pres_e;

  typedef enum logic [1:0] {
    CHG_UNKNOWN  = 2'd0,
    CHG_CHARGING = 2'd1,
    CHG_IDLE     = 2'd2
  } chg_e;

  typedef enum logic [1:0] {
    LVL_UNKNOWN  = 2'd0,
    LVL_FULL     = 2'd1,
    LVL_CRITICAL = 2'd2,
    LVL_SHUTOFF  = 2'd3
  } lvl_e;

  typedef struct packed {
    logic  pwr_ok;
    logic  usb_present;
    lvl_e  level;
    chg_e  chg_state;
    pres_e presence;
    logic  changed;
  } res_t;

endpackage

/* rtl/bplm_cfg_regs.sv */
// configuration register file of the battery monitor
// depends on bplm_pkg
module bplm_cfg_regs #(
  parameter int ADC_BITS  = bplm_pkg::AdcBitsDef,
  parameter int TICK_BITS = bplm_pkg::TickBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bplm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [TICK_BITS-1:0]         cfg_data_i,
  output logic [ADC_BITS-1:0]          vbus_thr_o,
  output logic [ADC_BITS-1:0]          pulse_thr_o,
  output logic [ADC_BITS-1:0]          full_thr_o,
  output logic [ADC_BITS-1:0]          crit_thr_o,
  output logic [bplm_pkg::CntW-1:0]    highs_needed_o,
  output logic [bplm_pkg::CntW-1:0]    level_rep_o,
  output logic [TICK_BITS-1:0]         bounce_win_o,
  output logic [TICK_BITS-1:0]         stable_win_o
);

  logic [ADC_BITS-1:0]       vbus_thr_q, pulse_thr_q, full_thr_q, crit_thr_q;
  logic [bplm_pkg::CntW-1:0] highs_q, level_rep_q;
  logic [TICK_BITS-1:0]      bounce_win_q, stable_win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbus_thr_q   <= ADC_BITS'(bplm_pkg::VbusThrRst);
      pulse_thr_q  <= ADC_BITS'(bplm_pkg::PulseThrRst);
      full_thr_q   <= ADC_BITS'(bplm_pkg::FullThrRst);
      crit_thr_q   <= ADC_BITS'(bplm_pkg::CritThrRst);
      highs_q      <= bplm_pkg::CntW'(bplm_pkg::HighsNeededRst);
      level_rep_q  <= bplm_pkg::CntW'(bplm_pkg::LevelRepRst);
      bounce_win_q <= TICK_BITS'(bplm_pkg::BounceWinRst);
      stable_win_q <= TICK_BITS'(bplm_pkg::StableWinRst);
    end else if (cfg_we_i) begin
      unique case (bplm_pkg::cfg_reg_e'(cfg_idx_i))
        bplm_pkg::REG_VBUS_THR:   vbus_thr_q   <= cfg_data_i[ADC_BITS-1:0];
        bplm_pkg::REG_PULSE_THR:  pulse_thr_q  <= cfg_data_i[ADC_BITS-1:0];
        bplm_pkg::REG_FULL_THR:   full_thr_q   <= cfg_data_i[ADC_BITS-1:0];
        bplm_pkg::REG_CRIT_THR:   crit_thr_q   <= cfg_data_i[ADC_BITS-1:0];
        bplm_pkg::REG_HIGHS:      highs_q      <= cfg_data_i[bplm_pkg::CntW-1:0];
        bplm_pkg::REG_LEVEL_REP:  level_rep_q  <= cfg_data_i[bplm_pkg::CntW-1:0];
        bplm_pkg::REG_BOUNCE_WIN: bounce_win_q <= cfg_data_i;
        bplm_pkg::REG_STABLE_WIN: stable_win_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign vbus_thr_o     = vbus_thr_q;
  assign pulse_thr_o    = pulse_thr_q;
  assign full_thr_o     = full_thr_q;
  assign crit_thr_o     = crit_thr_q;
  assign highs_needed_o = highs_q;
  assign level_rep_o    = level_rep_q;
  assign bounce_win_o   = bounce_win_q;
  assign stable_win_o   = stable_win_q;

endmodule

/* rtl/bplm_core.sv */
// monitor state registers and the combinational update for one transaction
// depends on bplm_pkg
module bplm_core #(
  parameter int ADC_BITS  = bplm_pkg::AdcBitsDef,
  parameter int TICK_BITS = bplm_pkg::TickBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  bplm_pkg::cmd_e            cmd_i,
  input  logic [ADC_BITS-1:0]       bat_first_i,
  input  logic [ADC_BITS-1:0]       bat_second_i,
  input  logic [ADC_BITS-1:0]       vbus_sample_i,
  input  logic                      charge_active_i,
  input  logic                      pgood_pin_i,
  input  logic [TICK_BITS-1:0]      now_ticks_i,
  input  logic [ADC_BITS-1:0]       vbus_thr_i,
  input  logic [ADC_BITS-1:0]       pulse_thr_i,
  input  logic [ADC_BITS-1:0]       full_thr_i,
  input  logic [ADC_BITS-1:0]       crit_thr_i,
  input  logic [bplm_pkg::CntW-1:0] highs_needed_i,
  input  logic [bplm_pkg::CntW-1:0] level_rep_i,
  input  logic [TICK_BITS-1:0]      bounce_win_i,
  input  logic [TICK_BITS-1:0]      stable_win_i,
  output bplm_pkg::res_t            res_o,
  output bplm_pkg::res_t            cur_o
);

  bplm_pkg::pres_e pres_q, pres_d;
  bplm_pkg::chg_e  charge_q, charge_d, want;
  bplm_pkg::lvl_e  level_q, level_d, pend_q, pend_d, rd;
  logic            usb_q, usb_d, usb_new, pgood_q, pgood_d, chg;
  logic [bplm_pkg::CntW-1:0] high_q, high_d, bounce_q, bounce_d, lrun_q, lrun_d;
  logic [bplm_pkg::CntW-1:0] lrun_inc, bounce_inc;
  logic [TICK_BITS-1:0]      last_q, last_d, gap;

  always_comb begin
    pres_d   = pres_q;
    charge_d = charge_q;
    level_d  = level_q;
    pend_d   = pend_q;
    usb_d    = usb_q;
    pgood_d  = pgood_q;
    high_d   = high_q;
    bounce_d = bounce_q;
    lrun_d   = lrun_q;
    last_d   = last_q;
    chg      = 1'b0;
    usb_new  = vbus_sample_i > vbus_thr_i;
    want     = charge_active_i ? bplm_pkg::CHG_CHARGING : bplm_pkg::CHG_IDLE;
    gap      = now_ticks_i - last_q;
    bounce_inc = (bounce_q != bplm_pkg::CntMax) ? bounce_q + 8'd1 : bounce_q;
    lrun_inc   = (lrun_q < level_rep_i) ? lrun_q + 8'd1 : lrun_q;
    if (bat_first_i >= full_thr_i) begin
      rd = bplm_pkg::LVL_FULL;
    end else if (bat_first_i >= crit_thr_i) begin
      rd = bplm_pkg::LVL_CRITICAL;
    end else begin
      rd = bplm_pkg::LVL_SHUTOFF;
    end

    unique case (cmd_i)
      bplm_pkg::CMD_ADC: begin
        if (usb_q != usb_new) begin
          usb_d = usb_new;
          chg   = 1'b1;
        end
        if (bat_first_i <= pulse_thr_i || bat_second_i <= pulse_thr_i) begin
          high_d = '0;
          if (pres_q != bplm_pkg::PRES_DISC) begin
            pres_d   = bplm_pkg::PRES_DISC;
            charge_d = bplm_pkg::CHG_IDLE;
            chg      = 1'b1;
          end
        end else if (high_q < highs_needed_i) begin
          high_d = high_q + 8'd1;
        end else if (!(usb_d && pres_q == bplm_pkg::PRES_DISC)) begin
          if (pres_q != bplm_pkg::PRES_CONN) begin
            pres_d   = bplm_pkg::PRES_CONN;
            charge_d = bplm_pkg::CHG_UNKNOWN;
            chg      = 1'b1;
          end
        end
        // level tracking only while the battery is not known to be gone
        if (pres_d != bplm_pkg::PRES_DISC) begin
          if (rd == pend_q) begin
            lrun_d = lrun_inc;
            if (lrun_inc >= level_rep_i && level_q != pend_q) begin
              level_d = pend_q;
              chg     = 1'b1;
            end
          end else begin
            pend_d = rd;
            lrun_d = 8'd1;
          end
        end
      end
      bplm_pkg::CMD_CHARGE: begin
        if (charge_q != want) begin
          // a stored time of zero means no earlier toggle to measure against
          if (last_q != '0) begin
            if (gap < bounce_win_i) begin
              bounce_d = bounce_inc;
              if (bounce_inc >= bplm_pkg::BouncesForDisc &&
                  pres_q != bplm_pkg::PRES_DISC) begin
                pres_d = bplm_pkg::PRES_DISC;
                chg    = 1'b1;
              end
            end else if (gap > stable_win_i) begin
              bounce_d = '0;
              if (usb_q && pres_q == bplm_pkg::PRES_DISC) begin
                pres_d = bplm_pkg::PRES_CONN;
                chg    = 1'b1;
              end
            end
          end
          last_d   = now_ticks_i;
          charge_d = want;
          if (pres_d != bplm_pkg::PRES_DISC) begin
            chg = 1'b1;
          end
        end
      end
      bplm_pkg::CMD_PGOOD: begin
        if (pgood_q != pgood_pin_i) begin
          pgood_d = pgood_pin_i;
          chg     = 1'b1;
        end
      end
      bplm_pkg::CMD_INIT: begin
        if (charge_q != want) begin
          charge_d = want;
          chg      = 1'b1;
        end
        if (pgood_q != pgood_pin_i) begin
          pgood_d = pgood_pin_i;
          chg     = 1'b1;
        end
      end
      default: ;
    endcase

    res_o.changed     = chg;
    res_o.presence    = pres_d;
    res_o.chg_state   = charge_d;
    res_o.level       = level_d;
    res_o.usb_present = usb_d;
    res_o.pwr_ok      = pgood_d;

    cur_o.changed     = 1'b0;
    cur_o.presence    = pres_q;
    cur_o.chg_state   = charge_q;
    cur_o.level       = level_q;
    cur_o.usb_present = usb_q;
    cur_o.pwr_ok      = pgood_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_q   <= bplm_pkg::PRES_UNKNOWN;
      charge_q <= bplm_pkg::CHG_UNKNOWN;
      level_q  <= bplm_pkg::LVL_UNKNOWN;
      pend_q   <= bplm_pkg::LVL_UNKNOWN;
      usb_q    <= 1'b0;
      pgood_q  <= 1'b0;
      high_q   <= '0;
      bounce_q <= '0;
      lrun_q   <= '0;
      last_q   <= '0;
    end else if (fire_i) begin
      pres_q   <= pres_d;
      charge_q <= charge_d;
      level_q  <= level_d;
      pend_q   <= pend_d;
      usb_q    <= usb_d;
      pgood_q  <= pgood_d;
      high_q   <= high_d;
      bounce_q <= bounce_d;
      lrun_q   <= lrun_d;
      last_q   <= last_d;
    end
  end

endmodule

/* rtl/battery_presence_level_monitor.sv */
// top level of the battery presence and level monitor: input register, core, result register
// depends on bplm_pkg, bplm_cfg_regs, bplm_core and the assertion macro header
//
// Takes one transaction per clock cycle when the result side keeps up; each item is
// processed combinationally from the input register against the state registers, so the
// result register is loaded when the item fires and the state for the next item is ready
// at once. s_axis_tready depends combinationally on m_axis_tready: the input register holds
// one item while the result register holds a finished one. Configuration writes go straight
// into the register file and are meant to happen only while the monitor is idle.
`include "battery_presence_level_monitor_assert.svh"

module battery_presence_level_monitor #(
  parameter int ADC_BITS  = bplm_pkg::AdcBitsDef,
  parameter int TICK_BITS = bplm_pkg::TickBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bplm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [TICK_BITS-1:0]         cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // bat_first, bat_second, vbus_sample, charge_active, pgood_pin, now_ticks, zero pad
  input  logic [((3 * ADC_BITS + 2 + TICK_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // cmd
  input  logic [1:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // changed, presence, chg_state, level, usb_present, pwr_ok, zero pad
  output logic [bplm_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int InUsedW = 3 * ADC_BITS + 2 + TICK_BITS;
  localparam int OutUsedW = $bits(bplm_pkg::res_t);

  logic                    in_vld_q, out_vld_q, out_ready, fire, s_accept;
  bplm_pkg::cmd_e          cmd_q;
  logic [InUsedW-1:0]      data_q;
  bplm_pkg::res_t          res_d, res_q, cur;

  logic [ADC_BITS-1:0]       vbus_thr, pulse_thr, full_thr, crit_thr;
  logic [bplm_pkg::CntW-1:0] highs_needed, level_rep;
  logic [TICK_BITS-1:0]      bounce_win, stable_win;

  assign out_ready     = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && out_ready;
  assign s_axis_tready = !in_vld_q || out_ready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_accept) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q  <= bplm_pkg::cmd_e'(s_axis_tuser);
      data_q <= s_axis_tdata[InUsedW-1:0];
    end
  end

  bplm_cfg_regs #(
    .ADC_BITS  (ADC_BITS),
    .TICK_BITS (TICK_BITS)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .vbus_thr_o     (vbus_thr),
    .pulse_thr_o    (pulse_thr),
    .full_thr_o     (full_thr),
    .crit_thr_o     (crit_thr),
    .highs_needed_o (highs_needed),
    .level_rep_o    (level_rep),
    .bounce_win_o   (bounce_win),
    .stable_win_o   (stable_win)
  );

  bplm_core #(
    .ADC_BITS  (ADC_BITS),
    .TICK_BITS (TICK_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .cmd_i           (cmd_q),
    .bat_first_i     (data_q[ADC_BITS-1:0]),
    .bat_second_i    (data_q[2*ADC_BITS-1:ADC_BITS]),
    .vbus_sample_i   (data_q[3*ADC_BITS-1:2*ADC_BITS]),
    .charge_active_i (data_q[3*ADC_BITS]),
    .pgood_pin_i     (data_q[3*ADC_BITS+1]),
    .now_ticks_i     (data_q[InUsedW-1:3*ADC_BITS+2]),
    .vbus_thr_i      (vbus_thr),
    .pulse_thr_i     (pulse_thr),
    .full_thr_i      (full_thr),
    .crit_thr_i      (crit_thr),
    .highs_needed_i  (highs_needed),
    .level_rep_i     (level_rep),
    .bounce_win_i    (bounce_win),
    .stable_win_i    (stable_win),
    .res_o           (res_d),
    .cur_o           (cur)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_ready) begin
      out_vld_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(bplm_pkg::OutDataW - OutUsedW){1'b0}}, res_q};

  // a held input item must block the slave side while the result register is stalled
  `BPLM_ASSERT_IMP(a_in_blocked, clk_i, rst_ni, in_vld_q && !out_ready, !s_axis_tready)
  // every processed item shows up as a result in the next cycle
  `BPLM_ASSERT_NXT(a_fire_to_out, clk_i, rst_ni, fire, m_axis_tvalid)
  // power-good items never touch presence, level or usb
  `BPLM_ASSERT_IMP(a_pgood_only, clk_i, rst_ni, fire && cmd_q == bplm_pkg::CMD_PGOOD, res_d.presence == cur.presence && res_d.level == cur.level && res_d.usb_present == cur.usb_present)

endmodule

/* tb/battery_presence_level_monitor_tb.sv */
`timescale 1ns / 100ps
// testbench for the battery presence and level monitor: directed, register and random traffic
// every status is checked against an in-bench model; depends on bplm_pkg and the top level
module battery_presence_level_monitor_tb;

  localparam int InDataBits = 72;
  localparam int CycleLimit = 300000;
  localparam int ResBits    = $bits(bplm_pkg::res_t);

  typedef struct {
    bplm_pkg::cmd_e cmd;
    logic [11:0]    bat_first;
    logic [11:0]    bat_second;
    logic [11:0]    vbus;
    logic           charge_on;
    logic           pgood_on;
    logic [31:0]    now_ticks;
  } monitor_in_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  bplm_pkg::cfg_reg_e           cfg_idx_i;
  logic [31:0]                  cfg_data_i;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  // bat_first, bat_second, vbus_sample, charge_active, pgood_pin, now_ticks, zero pad
  logic [InDataBits-1:0]        s_axis_tdata;
  // cmd
  logic [1:0]                   s_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  // changed, presence, chg_state, level, usb_present, pwr_ok, zero pad
  logic [bplm_pkg::OutDataW-1:0] m_axis_tdata;

  // shadow of the register file
  logic [11:0] vbus_thr   = 12'(bplm_pkg::VbusThrRst);
  logic [11:0] pulse_thr  = 12'(bplm_pkg::PulseThrRst);
  logic [11:0] full_thr   = 12'(bplm_pkg::FullThrRst);
  logic [11:0] crit_thr   = 12'(bplm_pkg::CritThrRst);
  logic [7:0]  highs_need = 8'(bplm_pkg::HighsNeededRst);
  logic [7:0]  level_rep  = 8'(bplm_pkg::LevelRepRst);
  logic [31:0] bounce_win = 32'(bplm_pkg::BounceWinRst);
  logic [31:0] stable_win = 32'(bplm_pkg::StableWinRst);

  // monitor state as the model sees it
  bplm_pkg::pres_e pres_q      = bplm_pkg::PRES_UNKNOWN;
  bplm_pkg::chg_e  chg_q       = bplm_pkg::CHG_UNKNOWN;
  bplm_pkg::lvl_e  lvl_q       = bplm_pkg::LVL_UNKNOWN;
  bplm_pkg::lvl_e  pend_lvl    = bplm_pkg::LVL_UNKNOWN;
  logic            usb_q       = 1'b0;
  logic            pgood_q     = 1'b0;
  logic [7:0]      high_run    = '0;
  logic [7:0]      bounce_run  = '0;
  logic [7:0]      level_run   = '0;
  logic [31:0]     last_toggle = '0;

  bplm_pkg::res_t  status_due_q[$];
  int              fail_count  = 0;
  int              items_sent  = 0;
  int              cycle_count = 0;
  int              hold_left   = 0;
  logic            gaps_on     = 1'b0;
  logic [31:0]     tick_now    = 32'd100;

  battery_presence_level_monitor i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic monitor_in_t mk(bplm_pkg::cmd_e cmd, logic [11:0] first,
                                     logic [11:0] second, logic [11:0] vbus, logic ch,
                                     logic pg, logic [31:0] now);
    monitor_in_t it;
    it.cmd        = cmd;
    it.bat_first  = first;
    it.bat_second = second;
    it.vbus       = vbus;
    it.charge_on  = ch;
    it.pgood_on   = pg;
    it.now_ticks  = now;
    return it;
  endfunction

  // uniform pick in lo..hi, clipped to the adc range; anything when the range is empty
  function automatic logic [11:0] pick(int lo, int hi);
    if (lo < 0) lo = 0;
    if (hi > 4095) hi = 4095;
    if (lo > hi) return 12'($urandom_range(4095));
    return 12'($urandom_range(hi, lo));
  endfunction

  function automatic bplm_pkg::res_t advance_monitor(monitor_in_t it);
    bplm_pkg::res_t r;
    logic           upd;
    logic           usb_now;
    bplm_pkg::lvl_e rd;
    bplm_pkg::chg_e want;
    logic [31:0]    gap;
    upd = 1'b0;
    case (it.cmd)
      bplm_pkg::CMD_ADC: begin
        usb_now = (it.vbus > vbus_thr);
        if (usb_q != usb_now) begin
          usb_q = usb_now;
          upd   = 1'b1;
        end
        if (it.bat_first <= pulse_thr || it.bat_second <= pulse_thr) begin
          high_run = '0;
          if (pres_q != bplm_pkg::PRES_DISC) begin
            pres_q = bplm_pkg::PRES_DISC;
            chg_q  = bplm_pkg::CHG_IDLE;
            upd    = 1'b1;
          end
        end else if (high_run < highs_need) begin
          high_run = high_run + 8'd1;
        end else if (!(usb_q && pres_q == bplm_pkg::PRES_DISC) &&
                     pres_q != bplm_pkg::PRES_CONN) begin
          pres_q = bplm_pkg::PRES_CONN;
          chg_q  = bplm_pkg::CHG_UNKNOWN;
          upd    = 1'b1;
        end
        // level is only tracked while the battery is not known to be gone
        if (pres_q != bplm_pkg::PRES_DISC) begin
          if (it.bat_first >= full_thr) rd = bplm_pkg::LVL_FULL;
          else if (it.bat_first >= crit_thr) rd = bplm_pkg::LVL_CRITICAL;
          else rd = bplm_pkg::LVL_SHUTOFF;
          if (rd == pend_lvl) begin
            if (level_run < level_rep) level_run = level_run + 8'd1;
            if (level_run >= level_rep && lvl_q != pend_lvl) begin
              lvl_q = pend_lvl;
              upd   = 1'b1;
            end
          end else begin
            pend_lvl  = rd;
            level_run = 8'd1;
          end
        end
      end
      bplm_pkg::CMD_CHARGE: begin
        want = it.charge_on ? bplm_pkg::CHG_CHARGING : bplm_pkg::CHG_IDLE;
        if (chg_q != want) begin
          // a stored time of zero means no earlier toggle to measure from
          if (last_toggle != '0) begin
            gap = it.now_ticks - last_toggle;
            if (gap < bounce_win) begin
              if (bounce_run != bplm_pkg::CntMax) bounce_run = bounce_run + 8'd1;
              if (bounce_run >= bplm_pkg::BouncesForDisc &&
                  pres_q != bplm_pkg::PRES_DISC) begin
                pres_q = bplm_pkg::PRES_DISC;
                upd    = 1'b1;
              end
            end else if (gap > stable_win) begin
              bounce_run = '0;
              if (usb_q && pres_q == bplm_pkg::PRES_DISC) begin
                pres_q = bplm_pkg::PRES_CONN;
                upd    = 1'b1;
              end
            end
          end
          last_toggle = it.now_ticks;
          chg_q       = want;
          if (pres_q != bplm_pkg::PRES_DISC) upd = 1'b1;
        end
      end
      bplm_pkg::CMD_PGOOD: begin
        if (pgood_q != it.pgood_on) begin
          pgood_q = it.pgood_on;
          upd     = 1'b1;
        end
      end
      default: begin
        want = it.charge_on ? bplm_pkg::CHG_CHARGING : bplm_pkg::CHG_IDLE;
        if (chg_q != want) begin
          chg_q = want;
          upd   = 1'b1;
        end
        if (pgood_q != it.pgood_on) begin
          pgood_q = it.pgood_on;
          upd     = 1'b1;
        end
      end
    endcase
    r.changed     = upd;
    r.presence    = pres_q;
    r.chg_state   = chg_q;
    r.level       = lvl_q;
    r.usb_present = usb_q;
    r.pwr_ok      = pgood_q;
    return r;
  endfunction

  // valid stays high after a transaction; with gaps on, the next item may drop it first
  task automatic send_item(input monitor_in_t it);
    while (gaps_on && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, it.now_ticks, it.pgood_on, it.charge_on, it.vbus,
                      it.bat_second, it.bat_first};
    s_axis_tuser  <= it.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    status_due_q.push_back(advance_monitor(it));
    items_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input bplm_pkg::cfg_reg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      bplm_pkg::REG_VBUS_THR:   vbus_thr   = val[11:0];
      bplm_pkg::REG_PULSE_THR:  pulse_thr  = val[11:0];
      bplm_pkg::REG_FULL_THR:   full_thr   = val[11:0];
      bplm_pkg::REG_CRIT_THR:   crit_thr   = val[11:0];
      bplm_pkg::REG_HIGHS:      highs_need = val[7:0];
      bplm_pkg::REG_LEVEL_REP:  level_rep  = val[7:0];
      bplm_pkg::REG_BOUNCE_WIN: bounce_win = val;
      default:                  stable_win = val;
    endcase
  endtask

  task automatic apply_setting(input logic [11:0] vb, input logic [11:0] pu,
                               input logic [11:0] fu, input logic [11:0] cr,
                               input logic [7:0] hi, input logic [7:0] lr,
                               input logic [31:0] bw, input logic [31:0] sw);
    settle();
    write_reg(bplm_pkg::REG_VBUS_THR, 32'(vb));
    write_reg(bplm_pkg::REG_PULSE_THR, 32'(pu));
    write_reg(bplm_pkg::REG_FULL_THR, 32'(fu));
    write_reg(bplm_pkg::REG_CRIT_THR, 32'(cr));
    write_reg(bplm_pkg::REG_HIGHS, 32'(hi));
    write_reg(bplm_pkg::REG_LEVEL_REP, 32'(lr));
    write_reg(bplm_pkg::REG_BOUNCE_WIN, bw);
    write_reg(bplm_pkg::REG_STABLE_WIN, sw);
  endtask

  // a run of pulse readings at one level, with the odd low reading mixed in
  task automatic adc_burst();
    int          n;
    int          cat;
    int          top;
    logic [11:0] first;
    logic [11:0] vb;
    top   = (int'(highs_need) > int'(level_rep)) ? int'(highs_need) : int'(level_rep);
    n     = $urandom_range((top + 4 > 24) ? 24 : top + 4, 1);
    cat   = $urandom_range(3);
    first = (cat == 0) ? pick(int'(full_thr), 4095) :
            (cat == 1) ? pick(int'(crit_thr), int'(full_thr) - 1) :
            (cat == 2) ? pick(int'(pulse_thr) + 1, int'(crit_thr) - 1) :
                         12'($urandom_range(4095));
    vb    = $urandom_range(1) ? pick(int'(vbus_thr) + 1, 4095) : pick(0, int'(vbus_thr));
    repeat (n) begin
      if ($urandom_range(99) < 8) begin
        if ($urandom_range(1))
          send_item(mk(bplm_pkg::CMD_ADC, pick(0, int'(pulse_thr)),
                       12'($urandom_range(4095)), vb,
                       1'($urandom_range(1)), 1'($urandom_range(1)), $urandom));
        else
          send_item(mk(bplm_pkg::CMD_ADC, first, pick(0, int'(pulse_thr)), vb,
                       1'($urandom_range(1)), 1'($urandom_range(1)), $urandom));
      end else begin
        send_item(mk(bplm_pkg::CMD_ADC, first, pick(int'(pulse_thr) + 1, 4095), vb,
                     1'($urandom_range(1)), 1'($urandom_range(1)), $urandom));
      end
    end
  endtask

  // charge pin toggles with gaps aimed at both windows and the band between them
  task automatic charge_burst();
    int          r;
    logic        pin;
    logic [31:0] step;
    pin = (chg_q == bplm_pkg::CHG_CHARGING);
    repeat ($urandom_range(6, 1)) begin
      if ($urandom_range(9) != 0) pin = !pin;
      r = $urandom_range(9);
      if (r < 5)
        step = (bounce_win == 0) ? 32'd0 :
               $urandom_range((bounce_win > 200) ? 199 : bounce_win - 1, 0);
      else if (r < 7)
        step = (bounce_win <= stable_win) ? $urandom_range(stable_win, bounce_win) : $urandom;
      else if (r < 9)
        step = stable_win + 32'd1 + $urandom_range(500);
      else
        step = $urandom;
      tick_now = tick_now + step;
      if ($urandom_range(30) == 0) tick_now = '0;
      send_item(mk(bplm_pkg::CMD_CHARGE, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                   12'($urandom_range(4095)), pin, 1'($urandom_range(1)), tick_now));
    end
  endtask

  task automatic random_mix(input int n);
    int target;
    int r;
    target = items_sent + n;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 45) adc_burst();
      else if (r < 75) charge_burst();
      else if (r < 83)
        send_item(mk(bplm_pkg::CMD_PGOOD, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                     12'($urandom_range(4095)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), $urandom));
      else if (r < 91)
        send_item(mk(bplm_pkg::CMD_INIT, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                     12'($urandom_range(4095)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), $urandom));
      else
        send_item(mk(bplm_pkg::cmd_e'($urandom_range(3)), 12'($urandom_range(4095)),
                     12'($urandom_range(4095)), 12'($urandom_range(4095)),
                     1'($urandom_range(1)), 1'($urandom_range(1)), $urandom));
    end
  endtask

  task automatic test_directed_cases();
    int k;
    gaps_on = 1'b0;
    send_item(mk(bplm_pkg::CMD_INIT, 12'd0, 12'd0, 12'd0, 1'b1, 1'b1, 32'd0));
    send_item(mk(bplm_pkg::CMD_INIT, 12'd0, 12'd0, 12'd0, 1'b1, 1'b1, 32'd0));
    send_item(mk(bplm_pkg::CMD_PGOOD, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send_item(mk(bplm_pkg::CMD_PGOOD, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send_item(mk(bplm_pkg::CMD_ADC, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 32'd0));
    // usb present blocks reconnection from a full run of high readings
    repeat (6)
      send_item(mk(bplm_pkg::CMD_ADC, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 1'b0, 32'd0));
    // a toggle stamped at zero leaves the next one untimed
    send_item(mk(bplm_pkg::CMD_CHARGE, 12'd0, 12'd0, 12'd0, 1'b1, 1'b0, 32'd0));
    send_item(mk(bplm_pkg::CMD_CHARGE, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 32'd5));
    // long quiet gap with usb present recovers presence
    send_item(mk(bplm_pkg::CMD_CHARGE, 12'd0, 12'd0, 12'd0, 1'b1, 1'b0, 32'd5000));
    for (k = 1; k <= 4; k++)
      send_item(mk(bplm_pkg::CMD_CHARGE, 12'd0, 12'd0, 12'd0, k[0] ? 1'b0 : 1'b1, 1'b0,
                   32'd5000 + 32'(10 * k)));
    send_item(mk(bplm_pkg::CMD_CHARGE, 12'd0, 12'd0, 12'd0, 1'b1, 1'b0, 32'd5045));
    send_item(mk(bplm_pkg::CMD_CHARGE, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 32'd6540));
    // tick counter wrap makes a short gap out of a numerically smaller stamp
    send_item(mk(bplm_pkg::CMD_CHARGE, 12'd0, 12'd0, 12'd0, 1'b1, 1'b0, 32'hFFFF_FF00));
    send_item(mk(bplm_pkg::CMD_CHARGE, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 32'h0000_0010));
    // reading equal to the pulse threshold is not high, vbus equal to its threshold no usb
    send_item(mk(bplm_pkg::CMD_ADC, 12'd1501, 12'd1500, 12'd500, 1'b0, 1'b1, 32'd0));
    settle();
  endtask

  task automatic test_lowered_targets();
    gaps_on = 1'b1;
    apply_setting(12'(bplm_pkg::VbusThrRst), 12'(bplm_pkg::PulseThrRst),
                  12'(bplm_pkg::FullThrRst), 12'(bplm_pkg::CritThrRst),
                  8'd30, 8'd40, 32'(bplm_pkg::BounceWinRst), 32'(bplm_pkg::StableWinRst));
    send_item(mk(bplm_pkg::CMD_ADC, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 32'd0));
    repeat (20)
      send_item(mk(bplm_pkg::CMD_ADC, 12'd4000, 12'd4000, 12'd0, 1'b0, 1'b0, 32'd0));
    settle();
    write_reg(bplm_pkg::REG_HIGHS, 32'd3);
    repeat (16)
      send_item(mk(bplm_pkg::CMD_ADC, 12'd4000, 12'd4000, 12'd0, 1'b0, 1'b0, 32'd0));
    settle();
    write_reg(bplm_pkg::REG_LEVEL_REP, 32'd4);
    send_item(mk(bplm_pkg::CMD_ADC, 12'd4000, 12'd4000, 12'd0, 1'b0, 1'b0, 32'd0));
    settle();
  endtask

  task automatic test_config_extremes();
    apply_setting(12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 8'd0, 32'd0, 32'd0);
    random_mix(30);
    apply_setting(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_mix(30);
    apply_setting(12'd2048, 12'd1000, 12'd3000, 12'd2000, 8'd1, 8'd1, 32'd50, 32'd100);
    random_mix(30);
    // critical above full, bounce window wider than the stable one
    apply_setting(12'd100, 12'd700, 12'd3000, 12'd3500, 8'd2, 8'd3, 32'd3000, 32'd500);
    random_mix(30);
    apply_setting(12'(bplm_pkg::VbusThrRst), 12'(bplm_pkg::PulseThrRst),
                  12'(bplm_pkg::FullThrRst), 12'(bplm_pkg::CritThrRst),
                  8'(bplm_pkg::HighsNeededRst), 8'(bplm_pkg::LevelRepRst),
                  32'(bplm_pkg::BounceWinRst), 32'(bplm_pkg::StableWinRst));
    random_mix(30);
  endtask

  task automatic test_input_stall();
    gaps_on   = 1'b1;
    hold_left = 80;
    random_mix(30);
    settle();
  endtask

  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 3; phase++) begin
      apply_setting(12'($urandom_range(4095)), 12'($urandom_range(3000)),
                    12'($urandom_range(4095)), 12'($urandom_range(4095)),
                    8'($urandom_range(8)), 8'($urandom_range(12)),
                    $urandom_range(3000), $urandom_range(6000));
      // middle phase runs with both sides flat out
      gaps_on = (phase != 1);
      random_mix(phase == 1 ? 100 : 150);
    end
    gaps_on = 1'b1;
    settle();
  endtask

  // result side: checks each status transaction and sets the ready for the next edge
  initial begin
    bplm_pkg::res_t got;
    bplm_pkg::res_t want;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = bplm_pkg::res_t'(m_axis_tdata[ResBits-1:0]);
        if (status_due_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected status, expected none, actual %h", $time, got);
        end else begin
          want = status_due_q.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: status mismatch, expected %h, actual %h", $time, want, got);
          end
        end
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= !(gaps_on && $urandom_range(99) < 26);
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= bplm_pkg::REG_VBUS_THR;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= bplm_pkg::CMD_ADC;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_lowered_targets();
    test_config_extremes();
    test_input_stall();
    test_random_traffic();
    settle();
    if (fail_count == 0 && status_due_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
